FILE: sv/mpeg_audio_header_decoder_core_assert.svh
// Assertion macros shared by the MPEG audio header decoder RTL
`ifndef MPEG_AUDIO_HEADER_DECODER_CORE_ASSERT_SVH
`define MPEG_AUDIO_HEADER_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define MAHD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define MAHD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mahd_pkg.sv
// Types, constants and lookup functions of the MPEG audio header decoder
package mahd_pkg;

    // Error codes, first failing check wins
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_SYNC    = 3'd1;
    localparam logic [2:0] ERR_MPEG25  = 3'd2;
    localparam logic [2:0] ERR_VERSION = 3'd3;
    localparam logic [2:0] ERR_LAYER   = 3'd4;
    localparam logic [2:0] ERR_BITRATE = 3'd5;
    localparam logic [2:0] ERR_RATE    = 3'd6;

    // Decoded version and layer
    localparam logic       VER_MPEG1 = 1'b0;
    localparam logic       VER_MPEG2 = 1'b1;
    localparam logic [1:0] LAYER_I   = 2'd0;
    localparam logic [1:0] LAYER_II  = 2'd1;
    localparam logic [1:0] LAYER_III = 2'd2;

    // Sample rate family, equal to the header's rate index
    localparam logic [1:0] FAM_441 = 2'd0;
    localparam logic [1:0] FAM_48  = 2'd1;
    localparam logic [1:0] FAM_32  = 2'd2;

    // Reciprocals for the frame length divide, scaled by 2^20
    localparam logic [18:0] RECIP_441 = 19'd2377;
    localparam logic [18:0] RECIP_3   = 19'd349525;
    localparam logic [8:0]  DIV_441   = 9'd441;
    localparam logic [8:0]  DIV_3     = 9'd3;
    localparam logic [8:0]  DIV_1     = 9'd1;
    localparam logic [9:0]  BPS_PER_KBPS = 10'd1000;

    // kbps; columns: M1 L1, M1 L2, M1 L3, M2 L1, M2 L2/L3
    localparam logic [8:0] RATE_KBPS [14][5] = '{
        '{ 32,  32,  32,  32,   8},
        '{ 64,  48,  40,  48,  16},
        '{ 96,  56,  48,  56,  24},
        '{128,  64,  56,  64,  32},
        '{160,  80,  64,  80,  40},
        '{192,  96,  80,  96,  48},
        '{224, 112,  96, 112,  56},
        '{256, 128, 112, 128,  64},
        '{288, 160, 128, 144,  80},
        '{320, 192, 160, 160,  96},
        '{352, 224, 192, 176, 112},
        '{384, 256, 224, 192, 128},
        '{416, 320, 256, 224, 144},
        '{448, 384, 320, 256, 160}
    };

    // Fields that ride along the pipeline untouched
    typedef struct packed {
        logic [2:0]  err;
        logic        ver;
        logic [1:0]  layer;
        logic        crc;
        logic        pad;
        logic [1:0]  chm;
        logic [15:0] fs_hz;
    } t_hdr_info;

    // Decode stage output
    typedef struct packed {
        t_hdr_info   info;
        logic [8:0]  kbps;
        logic [11:0] kmul;
        logic [1:0]  fam;
    } t_dec;

    // One result beat
    typedef struct packed {
        logic        valid_res;
        logic [2:0]  error_code;
        logic        mpeg_version;
        logic [1:0]  layer_number;
        logic        crc_present;
        logic [18:0] bitrate_bps;
        logic [15:0] sample_rate_hz;
        logic        padding_flag;
        logic [1:0]  channel_mode;
        logic [10:0] frame_bytes;
    } t_res;

    // Bitrate table read; zero outside the table
    function automatic logic [8:0] rate_kbps(input logic [3:0] bidx, input logic [2:0] col);
        logic [3:0] row;
        logic [8:0] kbps;
        row  = bidx - 4'd1;
        kbps = '0;
        if ((bidx inside {[4'd1:4'd14]}) && (col inside {[3'd0:3'd4]})) begin
            kbps = RATE_KBPS[row][col];
        end
        return kbps;
    endfunction

    // Sample rate in Hz from version and rate index
    function automatic logic [15:0] sample_rate(input logic ver, input logic [1:0] fam);
        logic [15:0] fs;
        case (fam)
            FAM_441: fs = ver ? 16'd22050 : 16'd44100;
            FAM_48:  fs = ver ? 16'd24000 : 16'd48000;
            FAM_32:  fs = ver ? 16'd16000 : 16'd32000;
            default: fs = '0;
        endcase
        return fs;
    endfunction

    // Slot multiplier with the half-rate and 44.1k scalings folded in
    function automatic logic [11:0] frame_mult(input logic ver, input logic [1:0] layer,
                                               input logic [1:0] fam);
        logic [11:0] k;
        case (layer)
            LAYER_I:  k = 12'd12;
            LAYER_II: k = 12'd144;
            default:  k = (ver == VER_MPEG2) ? 12'd72 : 12'd144;
        endcase
        if (ver == VER_MPEG2) begin
            k = {k[10:0], 1'b0};
        end
        if (fam == FAM_441) begin
            k = 12'(k * 12'd10);
        end
        return k;
    endfunction

endpackage

FILE: sv/mahd_hdr_if.sv
// Header word channel
interface mahd_hdr_if;
    logic        valid;
    logic        ready;
    logic [31:0] header_word;

    modport source (output valid, output header_word, input ready);
    modport sink   (input valid, input header_word, output ready);
endinterface

FILE: sv/mahd_res_if.sv
// Decoded result channel
interface mahd_res_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [2:0]  error_code;
    logic        mpeg_version;
    logic [1:0]  layer_number;
    logic        crc_present;
    logic [18:0] bitrate_bps;
    logic [15:0] sample_rate_hz;
    logic        padding_flag;
    logic [1:0]  channel_mode;
    logic [10:0] frame_bytes;

    modport source (output valid, output valid_res, output error_code, output mpeg_version,
                    output layer_number, output crc_present, output bitrate_bps,
                    output sample_rate_hz, output padding_flag, output channel_mode,
                    output frame_bytes, input ready);
    modport sink   (input valid, input valid_res, input error_code, input mpeg_version,
                    input layer_number, input crc_present, input bitrate_bps,
                    input sample_rate_hz, input padding_flag, input channel_mode,
                    input frame_bytes, output ready);
endinterface

FILE: sv/mahd_decode.sv
// Header field checks, table lookups and frame multiplier selection (one stage)
module mahd_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [31:0]   i_header_word,
    output logic          o_valid,
    input  logic          i_ready,
    output mahd_pkg::t_dec o_dec
);
    import mahd_pkg::*;

    // Raw header codes
    localparam logic [1:0] VCODE_MPEG25   = 2'b00;
    localparam logic [1:0] VCODE_RESERVED = 2'b01;
    localparam logic [1:0] VCODE_MPEG1    = 2'b11;
    localparam logic [1:0] LCODE_RESERVED = 2'b00;
    localparam logic [1:0] SIDX_RESERVED  = 2'b11;

    logic       r_v;
    t_dec       r_dec;
    t_dec       n_dec;
    logic       sync_ok;
    logic [1:0] v_code;
    logic [1:0] l_code;
    logic [3:0] bidx;
    logic [1:0] sidx;
    logic [2:0] col;

    assign sync_ok = (i_header_word[31:24] == 8'hFF) && (i_header_word[23:21] == 3'b111);
    assign v_code  = i_header_word[20:19];
    assign l_code  = i_header_word[18:17];
    assign bidx    = i_header_word[15:12];
    assign sidx    = i_header_word[11:10];

    // Field decode and first-failure error
    always_comb begin
        n_dec            = '0;
        n_dec.info.ver   = (v_code == VCODE_MPEG1) ? VER_MPEG1 : VER_MPEG2;
        n_dec.info.layer = 2'd3 - l_code;
        n_dec.info.crc   = ~i_header_word[16];
        n_dec.info.pad   = i_header_word[9];
        n_dec.info.chm   = i_header_word[7:6];
        n_dec.fam        = sidx;
        n_dec.info.fs_hz = sample_rate(n_dec.info.ver, sidx);

        // Bitrate column, MPEG-2 layers II and III share one
        if (n_dec.info.ver == VER_MPEG2) begin
            col = (n_dec.info.layer == LAYER_I) ? 3'd3 : 3'd4;
        end else begin
            col = {1'b0, n_dec.info.layer};
        end

        if (!sync_ok) begin
            n_dec.info.err = ERR_SYNC;
        end else if (v_code == VCODE_MPEG25) begin
            n_dec.info.err = ERR_MPEG25;
        end else if (v_code == VCODE_RESERVED) begin
            n_dec.info.err = ERR_VERSION;
        end else if (l_code == LCODE_RESERVED) begin
            n_dec.info.err = ERR_LAYER;
        end else if (!(bidx inside {[4'd1:4'd14]})) begin
            n_dec.info.err = ERR_BITRATE;
        end else if (sidx == SIDX_RESERVED) begin
            n_dec.info.err = ERR_RATE;
        end else begin
            n_dec.info.err = ERR_NONE;
        end

        // Rejected headers carry no rate, keeping the divide path in range
        if (n_dec.info.err == ERR_NONE) begin
            n_dec.kbps = rate_kbps(bidx, col);
            n_dec.kmul = frame_mult(n_dec.info.ver, n_dec.info.layer, sidx);
        end
    end

    assign o_ready = !r_v || i_ready;

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_v;
    assign o_dec   = r_dec;

endmodule

FILE: sv/mahd_frame_len.sv
// Frame length pipeline: rate product, reciprocal multiply, remainder fix-up
module mahd_frame_len (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mahd_pkg::t_dec i_dec,
    output logic           o_valid,
    input  logic           i_ready,
    output mahd_pkg::t_res o_res
);
    import mahd_pkg::*;

    `include "mpeg_audio_header_decoder_core_assert.svh"

    logic        rdy_a;
    logic        rdy_b;
    logic        rdy_c;

    // Stage A: scaled numerator and bitrate
    logic        r_a_v;
    t_hdr_info   r_a_info;
    logic [1:0]  r_a_fam;
    logic [19:0] r_a_y;
    logic [18:0] r_a_br;
    logic [20:0] n_prod;
    logic [19:0] n_y;
    logic [18:0] n_br;

    // Stage B: estimated quotient
    logic        r_b_v;
    t_hdr_info   r_b_info;
    logic [1:0]  r_b_fam;
    logic [19:0] r_b_y;
    logic [18:0] r_b_br;
    logic [10:0] r_b_q0;
    logic [18:0] n_recip;
    logic [38:0] n_qprod;
    logic [10:0] n_q0;

    // Stage C: corrected quotient and result
    logic        r_c_v;
    t_res        r_c_res;
    logic [8:0]  n_div;
    logic [19:0] n_qd;
    logic [19:0] n_rem;
    logic [10:0] n_q;
    logic [10:0] n_qp;
    t_res        n_res;

    assign rdy_c   = !r_c_v || i_ready;
    assign rdy_b   = !r_b_v || rdy_c;
    assign rdy_a   = !r_a_v || rdy_b;
    assign o_ready = rdy_a;

    // Stage A: slot multiplier times kbps, pre-shift for the 48k and 32k families
    always_comb begin
        n_prod = 21'(i_dec.kbps) * 21'(i_dec.kmul);
        n_br   = 19'(i_dec.kbps) * 19'(BPS_PER_KBPS);
        case (i_dec.fam)
            FAM_48:  n_y = {4'd0, n_prod[19:4]};
            FAM_32:  n_y = {4'd0, n_prod[20:5]};
            default: n_y = n_prod[19:0];
        endcase
    end

    // Stage B: quotient estimate, low by at most one
    always_comb begin
        case (r_a_fam)
            FAM_441: n_recip = RECIP_441;
            default: n_recip = RECIP_3;
        endcase
        n_qprod = 39'(r_a_y) * 39'(n_recip);
        if (r_a_fam == FAM_32) begin
            n_q0 = r_a_y[10:0];
        end else begin
            n_q0 = n_qprod[30:20];
        end
    end

    // Stage C: remainder check, padding and layer I slot size
    always_comb begin
        case (r_b_fam)
            FAM_441: n_div = DIV_441;
            FAM_48:  n_div = DIV_3;
            default: n_div = DIV_1;
        endcase
        n_qd  = 20'(r_b_q0) * 20'(n_div);
        n_rem = r_b_y - n_qd;
        n_q   = r_b_q0 + {10'd0, (n_rem >= {11'd0, n_div})};
        n_qp  = n_q + {10'd0, r_b_info.pad};

        n_res = '0;
        n_res.error_code = r_b_info.err;
        if (r_b_info.err == ERR_NONE) begin
            n_res.valid_res      = 1'b1;
            n_res.mpeg_version   = r_b_info.ver;
            n_res.layer_number   = r_b_info.layer;
            n_res.crc_present    = r_b_info.crc;
            n_res.bitrate_bps    = r_b_br;
            n_res.sample_rate_hz = r_b_info.fs_hz;
            n_res.padding_flag   = r_b_info.pad;
            n_res.channel_mode   = r_b_info.chm;
            if (r_b_info.layer == LAYER_I) begin
                n_res.frame_bytes = {n_qp[8:0], 2'b00};
            end else begin
                n_res.frame_bytes = n_qp;
            end
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_a_v <= i_valid;
            end
            if (rdy_b) begin
                r_b_v <= r_a_v;
            end
            if (rdy_c) begin
                r_c_v <= r_b_v;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (i_valid && rdy_a) begin
            r_a_info <= i_dec.info;
            r_a_fam  <= i_dec.fam;
            r_a_y    <= n_y;
            r_a_br   <= n_br;
        end
        if (r_a_v && rdy_b) begin
            r_b_info <= r_a_info;
            r_b_fam  <= r_a_fam;
            r_b_y    <= r_a_y;
            r_b_br   <= r_a_br;
            r_b_q0   <= n_q0;
        end
        if (r_b_v && rdy_c) begin
            r_c_res <= n_res;
        end
    end

    assign o_valid = r_c_v;
    assign o_res   = r_c_res;

    // Estimate is low by at most one divisor step
    `MAHD_ASSERT_NOW(a_rem_range, i_clk, i_rst_n, r_b_v, n_rem < {10'd0, n_div, 1'b0}, "frame length remainder out of range")
    // Exact shift path for the 32k family needs no fix-up
    `MAHD_ASSERT_NOW(a_shift_exact, i_clk, i_rst_n, r_b_v && (r_b_fam == FAM_32), n_rem == 20'd0, "32k family quotient not exact")
    // A beat leaving stage B lands in stage C
    `MAHD_ASSERT_NXT(a_b_to_c, i_clk, i_rst_n, r_b_v && rdy_c, r_c_v, "beat lost between stages B and C")

endmodule

FILE: sv/mpeg_audio_header_decoder_core.sv
// MPEG audio frame header decoder: one 32-bit header word per cycle, fully pipelined;
// a result passes the decode, rate product, reciprocal multiply, remainder fix-up and
// output register stages in turn after its header is taken, a depth set by the frame
// length divide done as a multiply by a constant reciprocal. Back-pressure on the
// result side stalls each stage only when the stage after it is full.
module mpeg_audio_header_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mahd_hdr_if.sink    i_hdr,
    mahd_res_if.source  o_res
);
    import mahd_pkg::*;

    `include "mpeg_audio_header_decoder_core_assert.svh"

    logic dec_valid;
    logic dec_ready;
    t_dec dec_beat;
    logic len_valid;
    logic len_ready;
    t_res len_beat;
    logic r_ov;
    t_res r_res;

    // Header checks and lookups
    mahd_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_hdr.valid),
        .o_ready       (i_hdr.ready),
        .i_header_word (i_hdr.header_word),
        .o_valid       (dec_valid),
        .i_ready       (dec_ready),
        .o_dec         (dec_beat)
    );

    // Frame length and result assembly
    mahd_frame_len u_frame_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_dec   (dec_beat),
        .o_valid (len_valid),
        .i_ready (len_ready),
        .o_res   (len_beat)
    );

    // Output register
    assign len_ready = !r_ov || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (len_ready) begin
            r_ov <= len_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (len_valid && len_ready) begin
            r_res <= len_beat;
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.valid_res      = r_res.valid_res;
    assign o_res.error_code     = r_res.error_code;
    assign o_res.mpeg_version   = r_res.mpeg_version;
    assign o_res.layer_number   = r_res.layer_number;
    assign o_res.crc_present    = r_res.crc_present;
    assign o_res.bitrate_bps    = r_res.bitrate_bps;
    assign o_res.sample_rate_hz = r_res.sample_rate_hz;
    assign o_res.padding_flag   = r_res.padding_flag;
    assign o_res.channel_mode   = r_res.channel_mode;
    assign o_res.frame_bytes    = r_res.frame_bytes;

    // Valid flag agrees with the error code
    `MAHD_ASSERT_NOW(a_ok_flag, i_clk, i_rst_n, r_ov, r_res.valid_res == (r_res.error_code == ERR_NONE), "valid_res disagrees with error_code")
    // Accepted headers carry a usable rate and length
    `MAHD_ASSERT_NOW(a_ok_fields, i_clk, i_rst_n, r_ov && r_res.valid_res, (r_res.sample_rate_hz != 16'd0) && (r_res.bitrate_bps != 19'd0) && (r_res.frame_bytes != 11'd0) && (r_res.layer_number != 2'd3), "accepted header with empty fields")
    // Rejected headers carry nothing but the error code
    `MAHD_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, r_ov && !r_res.valid_res, (r_res.bitrate_bps == 19'd0) && (r_res.sample_rate_hz == 16'd0) && (r_res.frame_bytes == 11'd0) && (r_res.channel_mode == 2'd0), "rejected header with non-zero fields")

endmodule
